>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/i2c_mag_pkg.sv
// ----------------------------------------------------------------------------
// i2c_mag_pkg
// Shared types and constants of the magnetometer burst-read sequencer
// ----------------------------------------------------------------------------
package i2c_mag_pkg;

	// request kinds
	typedef enum logic [1:0] {
		REQ_TRIGGER = 2'd0,
		REQ_EVENT   = 2'd1,
		REQ_CLEAR   = 2'd2
	} req_kind_t;

	// commands to the i2c master
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_TX      = 3'd2,
		CMD_RSTART  = 3'd3,
		CMD_RCV     = 3'd4,
		CMD_ACK     = 3'd5,
		CMD_NACK    = 3'd6,
		CMD_RELEASE = 3'd7
	} cmd_t;

	// session phases, idle outside a session
	typedef enum logic [3:0] {
		PH_ADDR_W = 4'd0,
		PH_REG    = 4'd1,
		PH_RSTART = 4'd2,
		PH_ADDR_R = 4'd3,
		PH_RCV_EN = 4'd4,
		PH_RCV    = 4'd5,
		PH_ACK    = 4'd6,
		PH_NACK   = 4'd7,
		PH_IDLE   = 4'd8
	} phase_t;

	localparam logic [7:0] DEV_ADDR_RST = 8'd60;
	localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
	localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
	localparam logic [7:0] DATA_REG     = 8'h03;
	localparam int unsigned RX_BYTES    = 6;
	localparam int unsigned IDX_W       = 3;

	// one request as held in the input stage
	typedef struct packed {
		logic [1:0] req_type;
		logic       bus_granted;
		logic       nack_seen;
		logic       bus_collision;
		logic       write_collision;
		logic       read_overflow;
		logic [7:0] rx_byte;
	} req_t;

	// sequencer decision for one request
	typedef struct packed {
		cmd_t               command;
		logic [7:0]         tx_byte;
		logic               done;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} seq_out_t;

	// accumulated sample state
	typedef struct packed {
		logic signed [31:0] sum_x;
		logic signed [31:0] sum_y;
		logic signed [31:0] sum_z;
		logic signed [15:0] last_x;
		logic signed [15:0] last_y;
		logic signed [15:0] last_z;
		logic [15:0]        sample_count;
		logic [15:0]        ready_count;
	} acc_state_t;

endpackage

>>> sv/i2c_mag_if.sv
// ----------------------------------------------------------------------------
// i2c_mag_req_if / i2c_mag_rsp_if
// Valid/ready channels for requests in and results out
// ----------------------------------------------------------------------------
interface i2c_mag_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       bus_granted;
	logic       nack_seen;
	logic       bus_collision;
	logic       write_collision;
	logic       read_overflow;
	logic [7:0] rx_byte;

	modport source (
		output valid, req_type, bus_granted, nack_seen, bus_collision,
			write_collision, read_overflow, rx_byte,
		input ready
	);
	modport sink (
		input valid, req_type, bus_granted, nack_seen, bus_collision,
			write_collision, read_overflow, rx_byte,
		output ready
	);
endinterface

interface i2c_mag_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic [7:0]         tx_byte;
	logic               sample_done;
	logic signed [31:0] sum_x;
	logic signed [31:0] sum_y;
	logic signed [31:0] sum_z;
	logic signed [15:0] last_x;
	logic signed [15:0] last_y;
	logic signed [15:0] last_z;
	logic [15:0]        sample_count;
	logic [15:0]        ready_count;

	modport source (
		output valid, command, tx_byte, sample_done, sum_x, sum_y, sum_z,
			last_x, last_y, last_z, sample_count, ready_count,
		input ready
	);
	modport sink (
		input valid, command, tx_byte, sample_done, sum_x, sum_y, sum_z,
			last_x, last_y, last_z, sample_count, ready_count,
		output ready
	);
endinterface

>>> sv/i2c_mag_seq.sv
// ----------------------------------------------------------------------------
// i2c_mag_seq
// Session state machine: issues i2c master commands, stores received bytes
// and decodes a finished six-byte burst into X, Y, Z
// ----------------------------------------------------------------------------
module i2c_mag_seq
	import i2c_mag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  req_t       req,
	input  logic [7:0] dev_addr,
	output seq_out_t   so
);

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d, idx_inc;
	logic [7:0]       rx_q [RX_BYTES];
	logic             rx_we;
	logic             active;
	logic             err;
	logic [15:0]      raw_x, raw_y, raw_z;

	// burst decode, big-endian pairs in X, Z, Y order
	assign raw_x = {rx_q[0], rx_q[1]};
	assign raw_z = {rx_q[2], rx_q[3]};
	assign raw_y = {rx_q[4], rx_q[5]};

	assign active  = (phase_q != PH_IDLE);
	assign err     = req.nack_seen | req.bus_collision | req.write_collision
		| req.read_overflow;
	assign idx_inc = idx_q + IDX_W'(1);

	// next phase and command
	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		rx_we      = 1'b0;
		so.command = CMD_NONE;
		so.tx_byte = 8'h00;
		so.done    = 1'b0;
		so.x       = $signed(16'(16'd0 - raw_x));
		so.y       = $signed(raw_y);
		so.z       = $signed(16'(16'd0 - raw_z));
		if (fire) begin
			case (req.req_type)
				REQ_TRIGGER: begin
					if (req.bus_granted && !active) begin
						phase_d    = PH_ADDR_W;
						so.command = CMD_START;
					end
				end
				REQ_EVENT: begin
					if (active && err) begin
						phase_d    = PH_IDLE;
						so.command = CMD_RELEASE;
					end else if (active) begin
						case (phase_q)
							PH_ADDR_W: begin
								so.command = CMD_TX;
								so.tx_byte = dev_addr & ADDR_WR_MASK;
								phase_d    = PH_REG;
							end
							PH_REG: begin
								so.command = CMD_TX;
								so.tx_byte = DATA_REG;
								phase_d    = PH_RSTART;
							end
							PH_RSTART: begin
								so.command = CMD_RSTART;
								phase_d    = PH_ADDR_R;
							end
							PH_ADDR_R: begin
								so.command = CMD_TX;
								so.tx_byte = dev_addr | ADDR_RD_BIT;
								phase_d    = PH_RCV_EN;
							end
							PH_RCV_EN: begin
								so.command = CMD_RCV;
								idx_d      = '0;
								phase_d    = PH_RCV;
							end
							PH_RCV: begin
								rx_we = (idx_q < IDX_W'(RX_BYTES));
								idx_d = idx_inc;
								if (idx_inc < IDX_W'(RX_BYTES)) begin
									so.command = CMD_ACK;
									phase_d    = PH_ACK;
								end else begin
									so.command = CMD_NACK;
									phase_d    = PH_NACK;
								end
							end
							PH_ACK: begin
								so.command = CMD_RCV;
								phase_d    = PH_RCV;
							end
							PH_NACK: begin
								so.command = CMD_RELEASE;
								so.done    = 1'b1;
								phase_d    = PH_IDLE;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// phase and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	// received byte store
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_q[idx_q] <= req.rx_byte;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_idx_range, idx_q <= IDX_W'(RX_BYTES), "byte index past burst length")
	`ASSERT_NEXT(a_start_phase, fire && so.command == CMD_START, phase_q == PH_ADDR_W, "start did not open a session")
	`ASSERT_NEXT(a_done_idle, fire && so.done, phase_q == PH_IDLE && idx_q == IDX_W'(RX_BYTES), "sample finished without a full burst")

endmodule

>>> sv/i2c_mag_acc.sv
// ----------------------------------------------------------------------------
// i2c_mag_acc
// Sample accumulator: latest values, wrapping sums and sample counters
// ----------------------------------------------------------------------------
module i2c_mag_acc
	import i2c_mag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       clear,
	input  seq_out_t   so,
	output acc_state_t nxt
);

	acc_state_t st_q;
	logic       fresh;
	logic [31:0] ext_x, ext_y, ext_z;

	assign fresh = (st_q.ready_count == 16'd0);
	assign ext_x = {{16{so.x[15]}}, so.x};
	assign ext_y = {{16{so.y[15]}}, so.y};
	assign ext_z = {{16{so.z[15]}}, so.z};

	// state after this request
	always_comb begin
		nxt = st_q;
		if (fire && so.done) begin
			nxt.last_x       = so.x;
			nxt.last_y       = so.y;
			nxt.last_z       = so.z;
			nxt.sum_x        = fresh ? $signed(ext_x) : $signed(32'(st_q.sum_x + ext_x));
			nxt.sum_y        = fresh ? $signed(ext_y) : $signed(32'(st_q.sum_y + ext_y));
			nxt.sum_z        = fresh ? $signed(ext_z) : $signed(32'(st_q.sum_z + ext_z));
			nxt.sample_count = 16'(st_q.sample_count + 16'd1);
			nxt.ready_count  = 16'(st_q.ready_count + 16'd1);
		end else if (fire && clear) begin
			nxt.ready_count = 16'd0;
		end
	end

	// accumulator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_cnt_step, fire && so.done, st_q.sample_count == 16'($past(st_q.sample_count) + 16'd1), "sample count did not advance")
	`ASSERT_NEXT(a_idle_hold, !fire, $stable(st_q), "accumulator changed without a request")

endmodule

>>> sv/i2c_magnetometer_read_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_magnetometer_read_sequencer_top
// Magnetometer burst-read sequencer for a shared i2c master
//
//   channel  dir  handshake    contents
//   req      in   valid/ready  request kind, grant, error flags, rx byte
//   rsp      out  valid/ready  command, tx byte, sample flag, sums, counts
//   cfg      in   cfg_we       device address byte
//
// One request per cycle sustained while rsp takes each result; a request is
// registered in the input stage, then in the result register, before rsp.valid.
// The path that sets the cycle is the phase decode feeding one 32-bit add.
// Reset clears phase, counters and sums at once; no clearing pass.
// While a result waits, one more request is taken into the input stage.
// ----------------------------------------------------------------------------
module i2c_magnetometer_read_sequencer_top
	import i2c_mag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	i2c_mag_req_if.sink   req,
	i2c_mag_rsp_if.source rsp
);

	logic [7:0] dev_addr_reg_q;
	logic       valid_s1;
	req_t       req_s1;
	logic       advance;
	logic       clear;
	seq_out_t   so;
	acc_state_t nxt;
	logic       rsp_valid_q;
	cmd_t       command_q;
	logic [7:0] tx_byte_q;
	logic       done_q;
	acc_state_t acc_q;

	// input stage moves when the result register is free or being drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign clear     = (req_s1.req_type == REQ_CLEAR);

	// device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_reg_q <= DEV_ADDR_RST;
		end else if (cfg_we) begin
			dev_addr_reg_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{req_type: req.req_type, bus_granted: req.bus_granted,
				nack_seen: req.nack_seen, bus_collision: req.bus_collision,
				write_collision: req.write_collision,
				read_overflow: req.read_overflow, rx_byte: req.rx_byte};
		end
	end

	i2c_mag_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.req      (req_s1),
		.dev_addr (dev_addr_reg_q),
		.so       (so)
	);

	i2c_mag_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.clear  (clear),
		.so     (so),
		.nxt    (nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			command_q <= so.command;
			tx_byte_q <= so.tx_byte;
			done_q    <= so.done;
			acc_q     <= nxt;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.command      = command_q;
	assign rsp.tx_byte      = tx_byte_q;
	assign rsp.sample_done  = done_q;
	assign rsp.sum_x        = acc_q.sum_x;
	assign rsp.sum_y        = acc_q.sum_y;
	assign rsp.sum_z        = acc_q.sum_z;
	assign rsp.last_x       = acc_q.last_x;
	assign rsp.last_y       = acc_q.last_y;
	assign rsp.last_z       = acc_q.last_z;
	assign rsp.sample_count = acc_q.sample_count;
	assign rsp.ready_count  = acc_q.ready_count;

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(req_s1), "request not held")
	`ASSERT_NEXT(a_rsp_load, advance, rsp_valid_q, "result register missed a request")

endmodule
